// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the escape encoder RTL.
// Each macro samples on clk; the reset-qualified form is skipped while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/dhe_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and helpers for the dollar-hex escape encoder.
// No dependencies; every RTL file of the block imports it.
package dhe_pkg;

  localparam int unsigned CNT_W       = 13;
  localparam int unsigned MAX_OUT_DEF = 4096;
  localparam int unsigned QUEUE_DEF   = 2;

  localparam logic [CNT_W-1:0] CNT_SAT = 13'h1FFF;

  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_TERM     = 8'h00;
  localparam logic [7:0] LOW_KEEP_SP = 8'h1F;
  localparam logic [7:0] LOW_ESC_SP  = 8'h20;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [3:0] DEC_MAX     = 4'h9;
  localparam logic [7:0] HEX_NUM_OFS = 8'h30;
  localparam logic [7:0] HEX_ALF_OFS = 8'h37;

  // Configuration register indexes
  localparam logic REG_ESCAPE_SPACE = 1'b0;
  localparam logic REG_MAX_OUT_LEN  = 1'b1;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       has_byte;
    logic       final_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  typedef struct packed {
    logic             escape_space;
    logic [CNT_W-1:0] max_out_len;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_LIT,
    JOB_ESC
  } job_kind_t;

  // One classified item waiting for expansion.
  typedef struct packed {
    logic [7:0] byte_in;
    job_kind_t  kind;
    logic       fin;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n <= DEC_MAX) begin
      return {4'h0, n} + HEX_NUM_OFS;
    end else begin
      return {4'h0, n} + HEX_ALF_OFS;
    end
  endfunction

endpackage

// ===== rtl/dhe_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input items, classifies each byte against the budget
// and keeps the running output count. Depends on dhe_pkg.
`include "assert_macros.svh"
module dhe_front import dhe_pkg::*; #(
  parameter int unsigned MAX_OUT = MAX_OUT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output job_t     push_job
);

  localparam logic [CNT_W-1:0] BUDGET_CAP =
    (MAX_OUT > int'(CNT_SAT)) ? CNT_SAT : CNT_W'(MAX_OUT);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] budget;
  logic [7:0]       low;
  logic             printable;
  logic             lit_fits;
  logic             esc_fits;
  logic             accept;
  job_kind_t        kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    budget    = (cfg.max_out_len > BUDGET_CAP) ? BUDGET_CAP : cfg.max_out_len;
    low       = cfg.escape_space ? LOW_ESC_SP : LOW_KEEP_SP;
    printable = (in_data.byte_in != CH_DOLLAR) && (in_data.byte_in > low) &&
                (in_data.byte_in < CH_DEL);
    lit_fits  = count < budget;
    esc_fits  = ({1'b0, count} + (CNT_W+1)'(2)) < {1'b0, budget};

    kind = JOB_NONE;
    if (in_data.has_byte) begin
      if (printable) begin
        if (lit_fits) kind = JOB_LIT;
      end else if (esc_fits) begin
        kind = JOB_ESC;
      end
    end

    push_job.byte_in = in_data.byte_in;
    push_job.kind    = kind;
    push_job.fin     = in_data.final_req;
    // drop items that produce nothing
    push = accept && ((kind != JOB_NONE) || in_data.final_req);

    count_next = count;
    if (in_data.final_req) begin
      count_next = '0;
    end else begin
      case (kind)
        JOB_LIT: count_next = count + CNT_W'(1);
        JOB_ESC: count_next = count + CNT_W'(3);
        default: count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  `ASSERT_CLK(a_push_needs_accept, push |-> (in_valid && in_ready), "push without accept")
  `ASSERT_CLK(a_fin_clears, (accept && in_data.final_req) |=> (count == '0),
              "final item did not clear count")

endmodule

// ===== rtl/dhe_fifo.sv =====
`timescale 1ns / 1ps
// Short job queue between the front end and the expander.
// Depth must be a power of two, at least 2. Depends on dhe_pkg.
`include "assert_macros.svh"
module dhe_fifo import dhe_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      case ({push, pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

  `ASSERT_CLK(a_no_overflow, !(push && full), "push into full queue")
  `ASSERT_CLK(a_no_underflow, !(pop && empty), "pop from empty queue")

endmodule

// ===== rtl/dhe_back.sv =====
`timescale 1ns / 1ps
// Expander: turns the job at the queue head into registered output characters, one per
// cycle unless the queue is empty or out_ready holds it off. Depends on dhe_pkg.
`include "assert_macros.svh"
module dhe_back import dhe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      head,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [1:0] step;
  logic [2:0] n_body;
  logic [2:0] n_total;
  logic       last;
  logic       load;
  out_item_t  nxt;

  always_comb begin
    case (head.kind)
      JOB_LIT: n_body = 3'd1;
      JOB_ESC: n_body = 3'd3;
      default: n_body = 3'd0;
    endcase
    n_total = n_body + {2'b00, head.fin};
    last    = ({1'b0, step} == (n_total - 3'd1));

    nxt.run_last   = last;
    nxt.string_end = 1'b0;
    nxt.out_char   = CH_TERM;
    if ({1'b0, step} < n_body) begin
      case (head.kind)
        JOB_LIT: nxt.out_char = head.byte_in;
        JOB_ESC: begin
          case (step)
            2'd0:    nxt.out_char = CH_DOLLAR;
            2'd1:    nxt.out_char = hex_digit(head.byte_in[7:4]);
            default: nxt.out_char = hex_digit(head.byte_in[3:0]);
          endcase
        end
        default: nxt.out_char = CH_TERM;
      endcase
    end else begin
      nxt.string_end = 1'b1;
    end

    // fill the output slot whenever it is free and the queue holds a job
    load = (!out_valid || out_ready) && !empty;
    pop  = load && last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      step      <= last ? 2'd0 : step + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_CLK(a_end_is_last, (out_valid && out_data.string_end) |-> out_data.run_last,
              "terminator not marked last")
  `ASSERT_CLK(a_step_idle, empty |-> (step == 2'd0), "step left over with empty queue")

endmodule

// ===== rtl/dollar_hex_escape_encoder_core.sv =====
`timescale 1ns / 1ps
// Top level of the dollar-hex escape encoder: configuration registers and
// the front end, job queue and expander. Depends on dhe_pkg and all dhe_ modules.
//
// Bytes enter on in_data, one item per cycle while in_ready is high. The
// expander delivers one character per cycle while it holds a job and
// out_ready is high. An item yields 1 character for a literal byte, 3 for an
// escape, plus 1 for the terminator of a final item; an item that yields
// nothing is dropped at the input. A queue of QUEUE_DEPTH classified items
// sits between input and output; an accepted item is written to a queue
// slot and its characters leave through the output register. MAX_OUT caps
// max_out_len as the per-string budget. Write cfg_index 0 for escape_space
// and 1 for max_out_len, only while the block is idle.
module dollar_hex_escape_encoder_core import dhe_pkg::*; #(
  parameter int unsigned MAX_OUT     = MAX_OUT_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam logic [CNT_W-1:0] LEN_RESET =
    (MAX_OUT > int'(CNT_SAT)) ? CNT_SAT : CNT_W'(MAX_OUT);

  cfg_t cfg;
  logic push;
  job_t push_job;
  logic pop;
  job_t head;
  logic empty;
  logic full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_space <= 1'b0;
      cfg.max_out_len  <= LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ESCAPE_SPACE: cfg.escape_space <= cfg_data[0];
        REG_MAX_OUT_LEN:  cfg.max_out_len  <= cfg_data;
        default:          cfg              <= cfg;
      endcase
    end
  end

  dhe_front #(
    .MAX_OUT (MAX_OUT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (full),
    .push     (push),
    .push_job (push_job)
  );

  dhe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  dhe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
